// ===== sv/tes_pkg.sv =====
package tes_pkg;

  localparam int unsigned Timers   = 16;
  localparam int unsigned SlotW    = $clog2(Timers);
  localparam int unsigned CntW     = $clog2(Timers + 1);
  localparam int unsigned TimeW    = 64;
  localparam int unsigned IvlW     = 40;
  localparam int unsigned IdW      = 8;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdExpire = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] when;
    logic [IvlW-1:0]  ivl;
  } cmd_t;

endpackage

// ===== sv/timer_expiry_scheduler.sv =====
// Add: the back end scans the table for the earliest stored expiry, then fills a free slot
// and gives the final beat. Expire: it rescans the table for the earliest due timer and
// emits a fired beat for it until none is due, then scans for the earliest stored expiry
// and gives the final beat. Each scan walks the timer table one slot a cycle.
// A two-entry command queue lets start be taken while the back end works.
// Reset clears the queue and all slot valid bits; the receiver cannot stall.
module timer_expiry_scheduler
  import tes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  timer_id_i,
  input  logic [63:0] expire_time_i,
  input  logic [39:0] repeat_interval_i,
  input  logic [63:0] now_time_i,
  output logic        strobe,
  output logic        fired_valid_o,
  output logic [7:0]  fired_id_o,
  output logic        new_min_o,
  output logic        table_full_o,
  output logic        next_valid_o,
  output logic [63:0] wake_time_o,
  output logic        last_o
);

  logic pop, full, empty, idle;
  cmd_t head;

  // hold start off only when the queue is full
  assign busy = full;

  tes_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i, .timer_id_i, .expire_time_i,
    .repeat_interval_i, .now_time_i, .pop_i(pop), .full_o(full),
    .empty_o(empty), .head_o(head)
  );

  tes_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .idle_o(idle), .strobe_o(strobe), .fired_valid_o, .fired_id_o,
    .new_min_o, .table_full_o, .next_valid_o, .wake_time_o, .last_o
  );

  // a beat never carries both a fired timer and the last mark
  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> !(fired_valid_o && last_o)) else $error("fired beat marked last");
  // the back end never pops while busy
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> idle && !empty) else $error("pop while not idle");
  // a final beat returns the back end to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && last_o) |-> idle) else $error("not idle after last beat");

endmodule

// ===== sv/tes_front.sv =====
module tes_front
  import tes_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       cmd_i,
  input  logic [7:0] timer_id_i,
  input  logic [63:0] expire_time_i,
  input  logic [39:0] repeat_interval_i,
  input  logic [63:0] now_time_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       empty_o,
  output cmd_t       head_o
);

  cmd_t                 mem_q [QDepth];
  logic [QPtrW-1:0]     wr_q, rd_q;
  logic [QPtrW:0]       cnt_q;
  logic                 push;
  cmd_t                 item;

  assign full_o  = (cnt_q == (QPtrW + 1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign push    = start_i && !full_o;
  assign head_o  = mem_q[rd_q];

  // classify: the time field depends on the command
  always_comb begin
    item.cmd      = cmd_i;
    item.timer_id = timer_id_i;
    item.when     = (cmd_i == CmdExpire) ? now_time_i : expire_time_i;
    item.ivl      = repeat_interval_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop_i};
    end
  end

endmodule

// ===== sv/tes_back.sv =====
module tes_back
  import tes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        idle_o,
  output logic        strobe_o,
  output logic        fired_valid_o,
  output logic [7:0]  fired_id_o,
  output logic        new_min_o,
  output logic        table_full_o,
  output logic        next_valid_o,
  output logic [63:0] wake_time_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    StIdle, StScan, StFire, StMin, StDone
  } state_e;

  state_e             state_q;
  cmd_t               cur_q;
  logic [Timers-1:0]  used_q, due_q;
  logic [TimeW-1:0]   exp_q [Timers];
  logic [IvlW-1:0]    ivl_q [Timers];
  logic [IdW-1:0]     id_q  [Timers];
  logic [CntW-1:0]    idx_q;
  logic               any_q, changed_q, fullf_q;
  logic [TimeW-1:0]   min_q;
  logic [SlotW-1:0]   best_q;
  logic [SlotW-1:0]   free_s;
  logic               free_any;
  logic [SlotW-1:0]   idx;
  logic [TimeW:0]     sum;

  assign idx = idx_q[SlotW-1:0];
  assign sum = {1'b0, cur_q.when} + {{(TimeW-IvlW+1){1'b0}}, ivl_q[best_q]};

  always_comb begin
    free_s   = '0;
    free_any = 1'b0;
    for (int i = Timers - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_s   = SlotW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign pop_o  = (state_q == StIdle) && !empty_i;
  assign idle_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cur_q         <= '0;
      used_q        <= '0;
      due_q         <= '0;
      strobe_o      <= 1'b0;
      last_o        <= 1'b0;
      fired_valid_o <= 1'b0;
      fired_id_o    <= '0;
      new_min_o     <= 1'b0;
      table_full_o  <= 1'b0;
      next_valid_o  <= 1'b0;
      wake_time_o   <= '0;
      idx_q         <= '0;
      any_q         <= 1'b0;
      changed_q     <= 1'b0;
      fullf_q       <= 1'b0;
      min_q         <= '0;
      best_q        <= '0;
    end else begin
      strobe_o <= 1'b0;
      last_o   <= 1'b0;
      case (state_q)
        StIdle: begin
          if (!empty_i) begin
            cur_q <= head_i;
            idx_q <= '0;
            any_q <= 1'b0;
            due_q <= '0;
            state_q <= (head_i.cmd == CmdAdd) ? StMin : StScan;
            changed_q <= 1'b0;
            fullf_q   <= 1'b0;
          end
        end
        // expire: walk slots, keep the earliest due one
        StScan: begin
          if (idx_q == CntW'(Timers)) begin
            if (any_q) begin
              state_q <= StFire;
            end else begin
              idx_q <= '0;
              state_q <= StMin;
            end
          end else begin
            if (used_q[idx] && !due_q[idx] && exp_q[idx] <= cur_q.when &&
                (!any_q || exp_q[idx] < min_q)) begin
              any_q  <= 1'b1;
              min_q  <= exp_q[idx];
              best_q <= idx;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        StFire: begin
          strobe_o      <= 1'b1;
          fired_valid_o <= 1'b1;
          fired_id_o    <= id_q[best_q];
          new_min_o     <= 1'b0;
          table_full_o  <= 1'b0;
          next_valid_o  <= 1'b0;
          wake_time_o   <= '0;
          if (ivl_q[best_q] != '0) begin
            due_q[best_q] <= 1'b1;
            exp_q[best_q] <= sum[TimeW] ? '1 : sum[TimeW-1:0];
          end else begin
            used_q[best_q] <= 1'b0;
          end
          idx_q   <= '0;
          any_q   <= 1'b0;
          state_q <= StScan;
        end
        // earliest stored expiry, one slot a cycle
        StMin: begin
          if (idx_q == CntW'(Timers)) begin
            if (cur_q.cmd == CmdAdd) begin
              if (free_any) begin
                used_q[free_s] <= 1'b1;
                exp_q[free_s]  <= cur_q.when;
                ivl_q[free_s]  <= cur_q.ivl;
                id_q[free_s]   <= cur_q.timer_id;
                changed_q      <= !any_q || cur_q.when < min_q;
                any_q          <= 1'b1;
                if (!any_q || cur_q.when < min_q) min_q <= cur_q.when;
              end else begin
                fullf_q <= 1'b1;
              end
            end
            state_q <= StDone;
          end else begin
            if (used_q[idx] && (!any_q || exp_q[idx] < min_q)) begin
              any_q <= 1'b1;
              min_q <= exp_q[idx];
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        StDone: begin
          strobe_o      <= 1'b1;
          last_o        <= 1'b1;
          fired_valid_o <= 1'b0;
          fired_id_o    <= '0;
          new_min_o     <= changed_q;
          table_full_o  <= fullf_q;
          next_valid_o  <= any_q;
          wake_time_o   <= any_q ? min_q : '0;
          state_q       <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
